[rtl/palt_pkg.sv]
// Package for the pressure altitude unit: field types, fixed constants, request codes,
// and the elaboration-time generator for the altitude breakpoint table.
// Depends on nothing; used by pressure_altitude_with_zeroing_unit.
package palt_pkg;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_MEASURE = 2'd0,
    REQ_LOAD    = 2'd1,
    REQ_ZERO    = 2'd2
  } req_e;

  // Field and datapath types.
  typedef logic        [23:0] raw_t;    // raw pressure word, 1/4096 hPa
  typedef logic        [21:0] off_t;    // offset into the table span
  typedef logic signed [20:0] alt_t;    // altitude or offset in cm
  typedef logic signed [21:0] tab_t;    // breakpoint altitude
  typedef logic signed [22:0] delta_t;  // difference of two breakpoints
  typedef logic        [21:0] rem_t;    // remainder within one segment
  typedef logic signed [45:0] prodi_t;  // delta times remainder
  typedef logic        [45:0] pmag_t;   // magnitude of that product
  typedef logic        [31:0] q2_t;     // magnitude scaled down by 4096
  typedef logic        [61:0] qm2_t;    // reciprocal product for the divide by 1000
  typedef logic        [22:0] tmag_t;   // magnitude of the interpolation term
  typedef logic signed [23:0] term_t;   // signed interpolation term
  typedef logic signed [23:0] altx_t;   // uncorrected altitude
  typedef logic signed [24:0] corr_t;   // altitude minus offset, before saturation
  typedef logic signed [25:0] sum_t;    // calibration sum
  typedef logic        [25:0] sumu_t;   // calibration sum magnitude
  typedef logic        [4:0]  cnt_t;    // calibration sample count

  // Table span in raw units.
  localparam raw_t RAW_LO   = 24'd1064960;
  localparam raw_t RAW_HI   = 24'd5160960;
  localparam int   OFF_W    = 22;
  localparam int   SPAN_SH  = 12;       // span is 4096 * 1000
  localparam int   SPAN_K   = 1000;
  localparam int   REMHI_W  = 10;       // bits of a value below 1000
  localparam int   HALF_SPAN = 2048000;

  // Reciprocals of 1000 used to divide by the span without a divider.
  localparam logic [20:0] DIV1K_M1 = 21'd1073742;
  localparam int          DIV1K_S1 = 30;
  localparam logic [29:0] DIV1K_M2 = 30'd549755814;
  localparam int          DIV1K_S2 = 39;
  localparam int          TMAG_W   = 23;

  // Output range.
  localparam int OUT_MAX = 1048575;
  localparam int OUT_MIN = -1048576;

  // Constants of the table generator.
  localparam longint unsigned G_RAW_LO   = 64'd1064960;
  localparam longint unsigned G_RAW_SPAN = 64'd4096000;
  localparam longint unsigned G_REF_RAW  = 64'd4150272;
  localparam longint          G_QONE     = 64'sd1073741824;
  localparam longint unsigned G_QHALF    = 64'd536870912;
  localparam longint          G_EXPO_Q   = 64'sd204315889;
  localparam longint          G_SCALE_CM = 64'sd4430769;

  // Unsigned long division by shift and subtract, for elaboration only.
  function automatic longint unsigned udiv_c(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rmd;
    int              b;
    quo = '0;
    rmd = '0;
    for (b = 63; b >= 0; b--) begin
      rmd = {rmd[62:0], num[b]};
      if (rmd >= den) begin
        rmd    = rmd - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Divide rounded to nearest, ties away from zero.
  function automatic longint rdiv_c(input longint n, input longint unsigned d);
    longint unsigned mag;
    longint unsigned r;
    if (n < 0) mag = -n;
    else mag = n;
    r = udiv_c(mag + (d >> 1), d);
    return (n < 0) ? -signed'(r) : signed'(r);
  endfunction

  // Q30 multiply rounded to nearest, ties away from zero.
  function automatic longint qmul_c(input longint a, input longint b);
    longint          p;
    longint unsigned mag;
    longint unsigned r;
    p = a * b;
    if (p < 0) mag = -p;
    else mag = p;
    r = (mag + G_QHALF) >> 30;
    return (p < 0) ? -signed'(r) : signed'(r);
  endfunction

  // Altitude in cm at breakpoint i of a table with n segments:
  // series logarithm, power scaling and series exponential, all in Q30.
  function automatic int alt_point(input int unsigned i, input int unsigned n);
    longint unsigned num;
    longint unsigned den;
    longint          xq;
    longint          zq;
    longint          zz;
    longint          term;
    longint          sum;
    longint          y;
    longint          e;
    longint          t;
    int unsigned     k;
    num = G_RAW_LO * 64'(n) + 64'(i) * G_RAW_SPAN;
    den = G_REF_RAW * 64'(n);
    xq  = signed'(udiv_c((num << 30) + (den >> 1), den));
    zq  = rdiv_c((xq - G_QONE) * G_QONE, unsigned'(xq + G_QONE));
    zz  = qmul_c(zq, zq);
    term = zq;
    sum  = 0;
    for (k = 0; k < 40; k++) begin
      sum  = sum + rdiv_c(term, 64'(2 * k + 1));
      term = qmul_c(term, zz);
    end
    y = qmul_c(2 * sum, G_EXPO_Q);
    e = G_QONE;
    t = G_QONE;
    for (k = 1; k <= 20; k++) begin
      t = rdiv_c(qmul_c(t, y), 64'(k));
      e = e + t;
    end
    return int'(rdiv_c((G_QONE - e) * G_SCALE_CM, unsigned'(G_QONE)));
  endfunction

endpackage

[rtl/pressure_altitude_with_zeroing_unit.sv]
// Pressure altitude unit with offset load and zero calibration.
// Depends on palt_pkg for types, constants and the breakpoint table generator.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one request (req_type_i,
//   raw_pressure_i). A measure request turns the pressure word into altitude
//   in cm minus the stored offset; a load request copies the configured
//   offset into the store; a zero request averages the next CAL_SAMPLES
//   measurements and stores their mean as the offset.
//   Output channel: out_valid_o / out_stall_i carry one result per request.
//   Configuration: cfg_we_i writes cfg_wdata_i into the manual offset
//   register; write it only while no request is in flight.
//   Throughput: one request per cycle while the receiver does not stall, set
//   by the eight-stage pipeline (input register, clamp and scale, segment
//   index, table read, interpolation multiply, rounding divide, sum and
//   calibration, offset and saturation).
//   Reset clears the pipeline, the offset store, the calibration state and
//   the manual offset register. When the receiver stalls, the held result
//   stays unchanged; stages behind it keep filling bubbles and the input
//   stalls only once every stage holds a request.
module pressure_altitude_with_zeroing_unit #(
  parameter int CAL_SAMPLES   = 20,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  palt_pkg::alt_t  cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      req_type_i,
  input  palt_pkg::raw_t  raw_pressure_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output palt_pkg::alt_t  altitude_cm_o,
  output logic            out_of_range_o,
  output logic            calibrating_o,
  output logic            offset_updated_o
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int PROD_W  = palt_pkg::OFF_W + IDX_W;
  localparam int Q1_W    = PROD_W - palt_pkg::SPAN_SH;
  localparam int QM1_W   = Q1_W + 21;
  localparam int NSTG    = 8;
  localparam int SUM_W   = $bits(palt_pkg::sum_t);
  localparam int SADD_W  = SUM_W + 1;
  localparam int CALM_W  = 32;
  localparam int SPROD_W = SADD_W + CALM_W;
  localparam longint CAL_M    = ((64'd1 << 31) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int     CAL_HALF = CAL_SAMPLES / 2;

  // Breakpoint table, built at elaboration.
  palt_pkg::tab_t alt_tab [TABLE_ENTRIES + 1];

  genvar gi;
  for (gi = 0; gi <= TABLE_ENTRIES; gi++) begin : g_tab
    localparam int TabVal = palt_pkg::alt_point(gi, TABLE_ENTRIES);
    assign alt_tab[gi] = palt_pkg::tab_t'(TabVal);
  end

  // Pipeline occupancy and per-stage advance.
  logic [NSTG:1] v_q;
  logic [NSTG:1] rdy;

  always_comb begin
    rdy[NSTG] = !v_q[NSTG] || !out_stall_i;
    for (int s = NSTG - 1; s >= 1; s--) begin
      rdy[s] = !v_q[s] || rdy[s + 1];
    end
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = v_q[NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[1]) v_q[1] <= in_valid_i;
      for (int s = 2; s <= NSTG; s++) begin
        if (rdy[s]) v_q[s] <= v_q[s - 1];
      end
    end
  end

  // Stage payload registers.
  logic [1:0]       req1_q, req2_q, req3_q, req4_q, req5_q, req6_q, req7_q;
  palt_pkg::raw_t   raw1_q;
  logic             oor2_q, oor3_q, oor4_q, oor5_q, oor6_q, oor7_q;
  logic [PROD_W-1:0] prod2_q;
  logic [Q1_W-1:0]  q1_3_q;
  logic [palt_pkg::SPAN_SH-1:0] lo12_3_q;
  logic [IDX_W-1:0] idx3_q;
  palt_pkg::tab_t   base4_q, base5_q, base6_q;
  palt_pkg::delta_t delta4_q;
  palt_pkg::rem_t   rem4_q;
  palt_pkg::prodi_t prodi5_q;
  palt_pkg::term_t  term6_q;
  palt_pkg::altx_t  alt7_q;
  palt_pkg::sum_t   fsum7_q;
  logic             done7_q, upd7_q, cal7_q;

  // Clamp to the table span and scale by the segment count.
  logic             oor_d2;
  palt_pkg::raw_t   raw_c;
  palt_pkg::off_t   off_d2;
  logic [PROD_W-1:0] prod_d2;

  always_comb begin
    oor_d2 = (raw1_q < palt_pkg::RAW_LO) || (raw1_q > palt_pkg::RAW_HI);
    if (raw1_q < palt_pkg::RAW_LO) begin
      raw_c = palt_pkg::RAW_LO;
    end else if (raw1_q > palt_pkg::RAW_HI) begin
      raw_c = palt_pkg::RAW_HI;
    end else begin
      raw_c = raw1_q;
    end
    off_d2  = palt_pkg::off_t'(raw_c - palt_pkg::RAW_LO);
    prod_d2 = PROD_W'(off_d2) * PROD_W'(TABLE_ENTRIES);
  end

  // Segment index: divide by 4096 with a shift, then by 1000 with a reciprocal.
  logic [Q1_W-1:0]  q1_d3;
  logic [QM1_W-1:0] qm1_d3;
  logic [IDX_W-1:0] idx_d3;

  always_comb begin
    q1_d3  = prod2_q[PROD_W-1:palt_pkg::SPAN_SH];
    qm1_d3 = QM1_W'(q1_d3) * QM1_W'(palt_pkg::DIV1K_M1);
    idx_d3 = qm1_d3[palt_pkg::DIV1K_S1 +: IDX_W];
  end

  // Remainder within the segment and the two breakpoints around it.
  logic [Q1_W-1:0]  remhi_d4;
  logic             last_d4;
  logic [IDX_W-1:0] idxn_d4;
  palt_pkg::rem_t   rem_d4;
  palt_pkg::tab_t   base_d4;
  palt_pkg::delta_t delta_d4;

  always_comb begin
    remhi_d4 = q1_3_q - Q1_W'(idx3_q) * Q1_W'(palt_pkg::SPAN_K);
    rem_d4   = {remhi_d4[palt_pkg::REMHI_W-1:0], lo12_3_q};
    last_d4  = (idx3_q == IDX_W'(TABLE_ENTRIES));
    idxn_d4  = last_d4 ? idx3_q : idx3_q + IDX_W'(1);
    base_d4  = alt_tab[idx3_q];
    delta_d4 = palt_pkg::delta_t'(alt_tab[idxn_d4]) - palt_pkg::delta_t'(base_d4);
  end

  // Interpolation product.
  palt_pkg::prodi_t prodi_d5;

  assign prodi_d5 = palt_pkg::prodi_t'(delta4_q) *
                    palt_pkg::prodi_t'(signed'({1'b0, rem4_q}));

  // Rounded divide of the product by the span, ties away from zero.
  logic             neg_d6;
  palt_pkg::pmag_t  pmag_d6, padd_d6;
  palt_pkg::q2_t    q2_d6;
  palt_pkg::qm2_t   qm2_d6;
  palt_pkg::tmag_t  tmag_d6;
  palt_pkg::term_t  term_d6;

  always_comb begin
    neg_d6  = prodi5_q[$bits(palt_pkg::prodi_t)-1];
    pmag_d6 = neg_d6 ? palt_pkg::pmag_t'(-prodi5_q) : palt_pkg::pmag_t'(prodi5_q);
    padd_d6 = pmag_d6 + palt_pkg::pmag_t'(palt_pkg::HALF_SPAN);
    q2_d6   = padd_d6[palt_pkg::SPAN_SH +: $bits(palt_pkg::q2_t)];
    qm2_d6  = palt_pkg::qm2_t'(q2_d6) * palt_pkg::qm2_t'(palt_pkg::DIV1K_M2);
    tmag_d6 = qm2_d6[palt_pkg::DIV1K_S2 +: palt_pkg::TMAG_W];
    term_d6 = neg_d6 ? -palt_pkg::term_t'(tmag_d6) : palt_pkg::term_t'(tmag_d6);
  end

  // Altitude sum and calibration bookkeeping.
  palt_pkg::sum_t  sum_q;
  palt_pkg::cnt_t  cnt_q;
  logic            active_q;
  palt_pkg::altx_t alt_d7;
  palt_pkg::sum_t  sum_acc, sum_d;
  palt_pkg::cnt_t  cnt_inc, cnt_d;
  logic            act_d, done_d7, upd_d7;
  logic            move6;

  assign move6 = v_q[6] && rdy[7];

  always_comb begin
    alt_d7  = palt_pkg::altx_t'(base6_q) + palt_pkg::altx_t'(term6_q);
    sum_acc = sum_q + palt_pkg::sum_t'(alt_d7);
    cnt_inc = cnt_q + palt_pkg::cnt_t'(1);
    act_d   = active_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    done_d7 = 1'b0;
    upd_d7  = 1'b0;
    case (req6_q)
      palt_pkg::REQ_MEASURE: begin
        if (active_q) begin
          if (cnt_inc >= palt_pkg::cnt_t'(CAL_SAMPLES)) begin
            done_d7 = 1'b1;
            upd_d7  = 1'b1;
            act_d   = 1'b0;
            sum_d   = '0;
            cnt_d   = '0;
          end else begin
            sum_d = sum_acc;
            cnt_d = cnt_inc;
          end
        end
      end
      palt_pkg::REQ_LOAD: begin
        act_d  = 1'b0;
        sum_d  = '0;
        cnt_d  = '0;
        upd_d7 = 1'b1;
      end
      palt_pkg::REQ_ZERO: begin
        act_d = 1'b1;
        sum_d = '0;
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else if (move6) begin
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      active_q <= act_d;
    end
  end

  // Offset subtraction, saturation and the calibration mean.
  palt_pkg::alt_t  offset_q;
  palt_pkg::alt_t  manual_q;
  palt_pkg::corr_t corr_d8;
  palt_pkg::alt_t  sat_d8;
  logic            sneg_d8;
  palt_pkg::sumu_t smag_d8;
  logic [SADD_W-1:0]  sadd_d8;
  logic [SPROD_W-1:0] sprod_d8;
  palt_pkg::sumu_t squo_d8;
  palt_pkg::sumu_t sres_d8;
  palt_pkg::alt_t  caloff_d8;
  logic            move7;

  assign move7 = v_q[7] && rdy[8];

  always_comb begin
    corr_d8 = palt_pkg::corr_t'(alt7_q) - palt_pkg::corr_t'(offset_q);
    if (corr_d8 > palt_pkg::corr_t'(palt_pkg::OUT_MAX)) begin
      sat_d8 = palt_pkg::alt_t'(palt_pkg::OUT_MAX);
    end else if (corr_d8 < palt_pkg::corr_t'(palt_pkg::OUT_MIN)) begin
      sat_d8 = palt_pkg::alt_t'(palt_pkg::OUT_MIN);
    end else begin
      sat_d8 = palt_pkg::alt_t'(corr_d8);
    end
    sneg_d8   = fsum7_q[SUM_W-1];
    smag_d8   = sneg_d8 ? palt_pkg::sumu_t'(-fsum7_q) : palt_pkg::sumu_t'(fsum7_q);
    sadd_d8   = SADD_W'(smag_d8) + SADD_W'(CAL_HALF);
    sprod_d8  = SPROD_W'(sadd_d8) * SPROD_W'(CAL_M);
    squo_d8   = sprod_d8[31 +: SUM_W];
    sres_d8   = sneg_d8 ? -squo_d8 : squo_d8;
    caloff_d8 = palt_pkg::alt_t'(sres_d8[$bits(palt_pkg::alt_t)-1:0]);
  end

  // Configuration register and offset store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      manual_q <= '0;
      offset_q <= '0;
    end else begin
      if (cfg_we_i) manual_q <= cfg_wdata_i;
      if (move7) begin
        if (req7_q == palt_pkg::REQ_LOAD) begin
          offset_q <= manual_q;
        end else if (done7_q) begin
          offset_q <= caloff_d8;
        end
      end
    end
  end

  // Result register.
  palt_pkg::alt_t altitude_q;
  logic           oor_q, cal_q, upd_q;

  always_ff @(posedge clk_i) begin
    if (rdy[NSTG]) begin
      altitude_q <= (req7_q == palt_pkg::REQ_MEASURE) ? sat_d8 : '0;
      oor_q      <= (req7_q == palt_pkg::REQ_MEASURE) && oor7_q;
      cal_q      <= cal7_q;
      upd_q      <= upd7_q;
    end
  end

  assign altitude_cm_o    = altitude_q;
  assign out_of_range_o   = oor_q;
  assign calibrating_o    = cal_q;
  assign offset_updated_o = upd_q;

  // Datapath registers of the earlier stages.
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      req1_q <= req_type_i;
      raw1_q <= raw_pressure_i;
    end
    if (rdy[2]) begin
      req2_q  <= req1_q;
      oor2_q  <= oor_d2;
      prod2_q <= prod_d2;
    end
    if (rdy[3]) begin
      req3_q   <= req2_q;
      oor3_q   <= oor2_q;
      q1_3_q   <= q1_d3;
      lo12_3_q <= prod2_q[palt_pkg::SPAN_SH-1:0];
      idx3_q   <= idx_d3;
    end
    if (rdy[4]) begin
      req4_q   <= req3_q;
      oor4_q   <= oor3_q;
      base4_q  <= base_d4;
      delta4_q <= delta_d4;
      rem4_q   <= rem_d4;
    end
    if (rdy[5]) begin
      req5_q   <= req4_q;
      oor5_q   <= oor4_q;
      base5_q  <= base4_q;
      prodi5_q <= prodi_d5;
    end
    if (rdy[6]) begin
      req6_q  <= req5_q;
      oor6_q  <= oor5_q;
      base6_q <= base5_q;
      term6_q <= term_d6;
    end
    if (rdy[7]) begin
      req7_q  <= req6_q;
      oor7_q  <= oor6_q;
      alt7_q  <= alt_d7;
      fsum7_q <= sum_acc;
      done7_q <= done_d7;
      upd7_q  <= upd_d7;
      cal7_q  <= act_d;
    end
  end

endmodule
